// File: sv/joint_bilateral_window_filter_assert.svh
// assertion macros for the joint bilateral window filter
`ifndef JOINT_BILATERAL_WINDOW_FILTER_ASSERT_SVH
`define JOINT_BILATERAL_WINDOW_FILTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define JBWF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define JBWF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define JBWF_ASSERT_SAME(lbl, ante, cons, msg)
`define JBWF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: sv/jbwf_pkg.sv
// shared types and constants of the joint bilateral window filter
`timescale 1ns / 1ps
package jbwf_pkg;
  localparam int unsigned DefMaxWidth  = 1024;
  localparam int unsigned DefMaxRadius = 7;
  localparam int unsigned DefChannels  = 3;
  localparam int unsigned TableSize    = 256;
  localparam int unsigned MaxHeight    = 1024;
  localparam int unsigned CfgDataW     = 11;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned ColorW       = 8;
  localparam int unsigned RgbW         = 24;
  localparam int unsigned WeightW      = 16;
  localparam int unsigned SumW         = 31;
  localparam int unsigned WsumW        = 23;
  localparam int unsigned RowW         = 10;
  localparam int unsigned HeightW      = 11;
  localparam int unsigned RadiusCfgW   = 3;

  localparam logic [CfgDataW-1:0]   ResetWidth  = 11'd640;
  localparam logic [CfgDataW-1:0]   ResetHeight = 11'd480;
  localparam logic [RadiusCfgW-1:0] ResetRadius = 3'd3;

  typedef enum logic [1:0] {
    MODE_PIXEL = 2'd0,
    MODE_FLUSH = 2'd1,
    MODE_LOAD  = 2'd2
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_RADIUS = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_CENTRE,
    ST_CWAIT,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } store_ctl_t;
endpackage

// File: sv/jbwf_line_store.sv
// guide and image line stores, one write and one registered read port
`timescale 1ns / 1ps
module jbwf_line_store import jbwf_pkg::*; #(
  parameter int unsigned Depth = DefMaxWidth * (2 * DefMaxRadius + 2)
) (
  input  logic                     clk_i,
  input  store_ctl_t               ctl_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  input  logic [RgbW-1:0]          wr_guide_i,
  input  logic [RgbW-1:0]          wr_pixel_i,
  output logic [RgbW-1:0]          rd_guide_o,
  output logic [RgbW-1:0]          rd_pixel_o
);
  logic [RgbW-1:0] guide_mem [Depth];
  logic [RgbW-1:0] pixel_mem [Depth];
  logic [RgbW-1:0] rd_guide_q;
  logic [RgbW-1:0] rd_pixel_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      guide_mem[wr_addr_i] <= wr_guide_i;
      pixel_mem[wr_addr_i] <= wr_pixel_i;
    end
    if (ctl_i.rd_en) begin
      rd_guide_q <= guide_mem[rd_addr_i];
      rd_pixel_q <= pixel_mem[rd_addr_i];
    end
  end

  assign rd_guide_o = rd_guide_q;
  assign rd_pixel_o = rd_pixel_q;
endmodule

// File: sv/joint_bilateral_window_filter.sv
// window clipped at frame edges; one request at a time, a new request is taken only when idle,
// the window scan is set by the single read port of the line stores (one pixel a cycle);
// a held output adds its wait; pixel and flush requests that give no result return to idle
// after the pending check, while table loads and unused modes do not leave idle
// reset: positions, pending count and config return to defaults at once;
// line stores and weight table are not cleared
`timescale 1ns / 1ps
`include "joint_bilateral_window_filter_assert.svh"
module joint_bilateral_window_filter import jbwf_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DefMaxWidth,
  parameter int unsigned MAX_RADIUS = DefMaxRadius,
  parameter int unsigned CHANNELS   = DefChannels
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          mode_i,
  input  logic [ColorW-1:0]   guide_red_i,
  input  logic [ColorW-1:0]   guide_green_i,
  input  logic [ColorW-1:0]   guide_blue_i,
  input  logic [ColorW-1:0]   pixel_ch0_i,
  input  logic [ColorW-1:0]   pixel_ch1_i,
  input  logic [ColorW-1:0]   pixel_ch2_i,
  input  logic [7:0]          table_index_i,
  input  logic [WeightW-1:0]  table_weight_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [SumW-1:0]     sum_ch0_o,
  output logic [SumW-1:0]     sum_ch1_o,
  output logic [SumW-1:0]     sum_ch2_o,
  output logic [WsumW-1:0]    weight_total_o,
  output logic                frame_last_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);
  localparam int unsigned Slots = 2 * MAX_RADIUS + 2;
  localparam int unsigned SlotW = $clog2(Slots);
  localparam int unsigned Depth = Slots * MAX_WIDTH;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned ColW  = $clog2(MAX_WIDTH);
  localparam int unsigned EffW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RadW  = $clog2(MAX_RADIUS + 1);
  localparam int unsigned PendW = $clog2(MAX_WIDTH * MaxHeight + 1);
  localparam int unsigned NWin  = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int unsigned ProdW = ColorW + WeightW;
  localparam int unsigned AccA  = ProdW + $clog2(NWin + 1);
  localparam int unsigned AccW  = (AccA > SumW) ? AccA : SumW + 1;
  localparam int unsigned WAccA = WeightW + $clog2(NWin + 1);
  localparam int unsigned WAccW = (WAccA > WsumW) ? WAccA : WsumW + 1;
  localparam logic [AccW-1:0]  SumMax  = AccW'({SumW{1'b1}});
  localparam logic [WAccW-1:0] WsumMax = WAccW'({WsumW{1'b1}});

  state_e state_q, state_d;

  logic [CfgDataW-1:0]   cfg_w_q, cfg_h_q;
  logic [RadiusCfgW-1:0] cfg_r_q;
  logic [EffW-1:0]       eff_w;
  logic [HeightW-1:0]    eff_h;
  logic [RadW-1:0]       eff_r;
  logic [ColW-1:0]       wm1;
  logic [RowW-1:0]       hm1;
  logic [PendW-1:0]      hw_q, lag_q, hw_c, lag_c;

  logic [1:0]            mode_q;
  logic [ColW-1:0]       in_col_q, out_col_q;
  logic [RowW-1:0]       in_row_q, out_row_q;
  logic [SlotW-1:0]      in_slot_q, out_slot_q;
  logic [PendW-1:0]      pending_q, pend_inc;

  logic [RowW-1:0]       y0_c, y1_c, y_q, y1_q;
  logic [ColW-1:0]       x0_c, x1_c, x_q, x0_q, x1_q;
  logic [SlotW-1:0]      slot0_c, slot_q;
  logic [RowW:0]         ysum, ksub;
  logic [ColW:0]         xsum;
  logic [SlotW:0]        slot_ext;

  store_ctl_t            st_ctl;
  logic [AddrW-1:0]      wr_addr, rd_addr;
  logic [RgbW-1:0]       rd_guide, rd_pixel, centre_q;

  logic [WeightW-1:0]    tbl_mem [TableSize];
  logic [WeightW-1:0]    tab_q, wt_s3_q;
  logic [7:0]            diff_max;
  logic [RgbW-1:0]       pix_s2_q;
  logic                  v1_q, v2_q, v3_q;
  logic [ProdW-1:0]      prod_q [3];
  logic [AccW-1:0]       acc_q [3];
  logic [WAccW-1:0]      wacc_q;

  logic                  in_acc, out_load;
  logic                  out_valid_q, frame_last_q;
  logic [SumW-1:0]       sum_q [3];
  logic [WsumW-1:0]      wsum_q;

  // effective config
  always_comb begin
    if (cfg_w_q == '0) begin
      eff_w = EffW'(1);
    end else if (int'(cfg_w_q) > int'(MAX_WIDTH)) begin
      eff_w = EffW'(MAX_WIDTH);
    end else begin
      eff_w = EffW'(cfg_w_q);
    end
    if (cfg_h_q == '0) begin
      eff_h = HeightW'(1);
    end else if (int'(cfg_h_q) > int'(MaxHeight)) begin
      eff_h = HeightW'(MaxHeight);
    end else begin
      eff_h = cfg_h_q;
    end
    if (int'(cfg_r_q) > int'(MAX_RADIUS)) begin
      eff_r = RadW'(MAX_RADIUS);
    end else begin
      eff_r = RadW'(cfg_r_q);
    end
    wm1  = ColW'(eff_w - EffW'(1));
    hm1  = RowW'(eff_h - HeightW'(1));
    hw_c = PendW'(eff_w) * PendW'(eff_h);
    lag_c = PendW'(eff_r) * PendW'(eff_w) + PendW'(eff_r);
    if (lag_c > hw_c - PendW'(1)) begin
      lag_c = hw_c - PendW'(1);
    end
  end

  // window bounds around the output position
  always_comb begin
    y0_c = (out_row_q >= RowW'(eff_r)) ? out_row_q - RowW'(eff_r) : '0;
    ysum = {1'b0, out_row_q} + (RowW + 1)'(eff_r);
    y1_c = (ysum > {1'b0, hm1}) ? hm1 : ysum[RowW-1:0];
    x0_c = (out_col_q >= ColW'(eff_r)) ? out_col_q - ColW'(eff_r) : '0;
    xsum = {1'b0, out_col_q} + (ColW + 1)'(eff_r);
    x1_c = (xsum > {1'b0, wm1}) ? wm1 : xsum[ColW-1:0];
    ksub = {1'b0, out_row_q - y0_c};
    if ((RowW + 1)'(out_slot_q) >= ksub) begin
      slot_ext = {1'b0, out_slot_q} - (SlotW + 1)'(ksub);
    end else begin
      slot_ext = {1'b0, out_slot_q} + (SlotW + 1)'(Slots) - (SlotW + 1)'(ksub);
    end
    slot0_c = slot_ext[SlotW-1:0];
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  assign pend_inc   = (pending_q < hw_q) ? pending_q + PendW'(1) : pending_q;

  assign st_ctl.wr_en = in_acc && (mode_i == MODE_PIXEL);
  assign st_ctl.rd_en = (state_q == ST_CENTRE) || (state_q == ST_SCAN);
  assign wr_addr = AddrW'(in_slot_q) * AddrW'(MAX_WIDTH) + AddrW'(in_col_q);
  assign rd_addr = (state_q == ST_CENTRE)
                 ? AddrW'(out_slot_q) * AddrW'(MAX_WIDTH) + AddrW'(out_col_q)
                 : AddrW'(slot_q) * AddrW'(MAX_WIDTH) + AddrW'(x_q);

  jbwf_line_store #(
    .Depth(Depth)
  ) u_store (
    .clk_i      (clk_i),
    .ctl_i      (st_ctl),
    .wr_addr_i  (wr_addr),
    .rd_addr_i  (rd_addr),
    .wr_guide_i ({guide_blue_i, guide_green_i, guide_red_i}),
    .wr_pixel_i ({pixel_ch2_i, pixel_ch1_i, pixel_ch0_i}),
    .rd_guide_o (rd_guide),
    .rd_pixel_o (rd_pixel)
  );

  // largest per-channel guide difference
  always_comb begin
    logic [ColorW-1:0] u, v, e;
    diff_max = '0;
    for (int c = 0; c < 3; c++) begin
      u = rd_guide[c*ColorW +: ColorW];
      v = centre_q[c*ColorW +: ColorW];
      e = (u > v) ? u - v : v - u;
      if (e > diff_max) begin
        diff_max = e;
      end
    end
  end

  // weight table and datapath stages
  always_ff @(posedge clk_i) begin
    if (in_acc && (mode_i == MODE_LOAD)) begin
      tbl_mem[table_index_i] <= table_weight_i;
    end
    if (v1_q) begin
      tab_q    <= tbl_mem[diff_max];
      pix_s2_q <= rd_pixel;
    end
    if (v2_q) begin
      for (int c = 0; c < 3; c++) begin
        prod_q[c] <= ProdW'(pix_s2_q[c*ColorW +: ColorW]) * ProdW'(tab_q);
      end
      wt_s3_q <= tab_q;
    end
    if (state_q == ST_CWAIT) begin
      centre_q <= rd_guide;
    end
    if (state_q == ST_CENTRE) begin
      for (int c = 0; c < 3; c++) begin
        acc_q[c] <= '0;
      end
      wacc_q <= '0;
    end else if (v3_q) begin
      for (int c = 0; c < 3; c++) begin
        acc_q[c] <= acc_q[c] + AccW'(prod_q[c]);
      end
      wacc_q <= wacc_q + WAccW'(wt_s3_q);
    end
    if (out_load) begin
      for (int c = 0; c < 3; c++) begin
        if (c >= int'(CHANNELS)) begin
          sum_q[c] <= '0;
        end else if (acc_q[c] > SumMax) begin
          sum_q[c] <= '1;
        end else begin
          sum_q[c] <= acc_q[c][SumW-1:0];
        end
      end
      wsum_q       <= (wacc_q > WsumMax) ? '1 : wacc_q[WsumW-1:0];
      frame_last_q <= (out_row_q == hm1) && (out_col_q == wm1);
    end
    if (state_q == ST_CENTRE) begin
      y1_q <= y1_c;
      x0_q <= x0_c;
      x1_q <= x1_c;
    end
    if (in_acc) begin
      mode_q <= mode_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ((mode_i == MODE_PIXEL) || (mode_i == MODE_FLUSH)) ? ST_CHECK : ST_IDLE;
        end
      end
      ST_CHECK: begin
        if (mode_q == MODE_PIXEL) begin
          state_d = (pend_inc > lag_q) ? ST_CENTRE : ST_IDLE;
        end else begin
          state_d = (pending_q != '0) ? ST_CENTRE : ST_IDLE;
        end
      end
      ST_CENTRE: state_d = ST_CWAIT;
      ST_CWAIT:  state_d = ST_SCAN;
      ST_SCAN: begin
        if ((x_q == x1_q) && (y_q == y1_q)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v1_q && !v2_q && !v3_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q     <= ResetWidth;
      cfg_h_q     <= ResetHeight;
      cfg_r_q     <= ResetRadius;
      hw_q        <= '0;
      lag_q       <= '0;
      in_col_q    <= '0;
      in_row_q    <= '0;
      in_slot_q   <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_slot_q  <= '0;
      pending_q   <= '0;
      y_q         <= '0;
      x_q         <= '0;
      slot_q      <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      hw_q  <= hw_c;
      lag_q <= lag_c;
      v1_q  <= (state_q == ST_SCAN);
      v2_q  <= v1_q;
      v3_q  <= v2_q;

      if (in_acc && (mode_i == MODE_PIXEL)) begin
        if ((EffW + 1)'(in_col_q) + (EffW + 1)'(1) >= (EffW + 1)'(eff_w)) begin
          in_col_q <= '0;
          if ((HeightW + 1)'(in_row_q) + (HeightW + 1)'(1) >= (HeightW + 1)'(eff_h)) begin
            in_row_q  <= '0;
            in_slot_q <= '0;
          end else begin
            in_row_q  <= in_row_q + RowW'(1);
            in_slot_q <= (int'(in_slot_q) == Slots - 1) ? '0 : in_slot_q + SlotW'(1);
          end
        end else begin
          in_col_q <= in_col_q + ColW'(1);
        end
      end

      if (state_q == ST_CHECK) begin
        if (mode_q == MODE_PIXEL) begin
          pending_q <= (pend_inc > lag_q) ? pend_inc - PendW'(1) : pend_inc;
        end else if (pending_q != '0) begin
          pending_q <= pending_q - PendW'(1);
        end
      end

      if (state_q == ST_CENTRE) begin
        y_q    <= y0_c;
        x_q    <= x0_c;
        slot_q <= slot0_c;
      end else if (state_q == ST_SCAN) begin
        if (x_q == x1_q) begin
          x_q <= x0_q;
          y_q <= y_q + RowW'(1);
          slot_q <= (int'(slot_q) == Slots - 1) ? '0 : slot_q + SlotW'(1);
        end else begin
          x_q <= x_q + ColW'(1);
        end
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
        if (out_col_q == wm1) begin
          out_col_q <= '0;
          if (out_row_q == hm1) begin
            out_row_q  <= '0;
            out_slot_q <= '0;
          end else begin
            out_row_q  <= out_row_q + RowW'(1);
            out_slot_q <= (int'(out_slot_q) == Slots - 1) ? '0 : out_slot_q + SlotW'(1);
          end
        end else begin
          out_col_q <= out_col_q + ColW'(1);
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_WIDTH:  cfg_w_q <= cfg_data_i;
          CFG_HEIGHT: cfg_h_q <= cfg_data_i;
          CFG_RADIUS: cfg_r_q <= cfg_data_i[RadiusCfgW-1:0];
          default: ;
        endcase
        if ((cfg_index_i == CFG_WIDTH) || (cfg_index_i == CFG_HEIGHT) ||
            (cfg_index_i == CFG_RADIUS)) begin
          in_col_q   <= '0;
          in_row_q   <= '0;
          in_slot_q  <= '0;
          out_col_q  <= '0;
          out_row_q  <= '0;
          out_slot_q <= '0;
          pending_q  <= '0;
        end
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sum_ch0_o      = sum_q[0];
  assign sum_ch1_o      = sum_q[1];
  assign sum_ch2_o      = sum_q[2];
  assign weight_total_o = wsum_q;
  assign frame_last_o   = frame_last_q;

  `JBWF_ASSERT_SAME(a_push_pipe_empty, out_load, !v1_q && !v2_q && !v3_q, "pipe busy at push")
  `JBWF_ASSERT_SAME(a_pending_bound, 1'b1, pending_q <= hw_q, "pending above frame size")
  `JBWF_ASSERT_NEXT(a_scan_follows, state_q == ST_CWAIT, state_q == ST_SCAN, "no window scan")
endmodule
